FILE: src/slxfr_pkg.sv
// Package for the sync/length/XOR frame receiver.
// Holds the phase and result-kind types, sync constants and register indexes.
// No dependencies.
package slxfr_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hBE;
	localparam logic [7:0] SYNC_SECOND = 8'hEF;

	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEN_ID0 = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEN_ID1 = 8'd1;

	localparam logic [7:0] CFG_LEN_RESET = 8'd1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_LEN,
		PH_ID,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BAD      = 2'd2,
		KIND_MISMATCH = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_id;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] frame_length;
		logic [7:0] bytes_seen;
	} fsm_status_t;

endpackage

FILE: src/slxfr_frame_fsm.sv
// Frame state machine: phase, length, byte count, running XOR and id registers.
// Consumes one byte per step and forms at most one result. Uses slxfr_pkg.
module slxfr_frame_fsm import slxfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  len_id0,
	input  logic [7:0]  len_id1,
	output logic        res_valid,
	output result_t     res,
	output fsm_status_t status
);

	phase_t     phase_q, phase_d;
	logic [7:0] frame_length_q, frame_length_d;
	logic [7:0] bytes_seen_q, bytes_seen_d;
	logic [7:0] running_xor_q, running_xor_d;
	logic [7:0] current_id_q, current_id_d;
	logic [7:0] selected_length_q, selected_length_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_HUNT;
			frame_length_q    <= 8'd0;
			bytes_seen_q      <= 8'd0;
			running_xor_q     <= 8'd0;
			current_id_q      <= 8'd0;
			selected_length_q <= 8'd0;
		end else begin
			phase_q           <= phase_d;
			frame_length_q    <= frame_length_d;
			bytes_seen_q      <= bytes_seen_d;
			running_xor_q     <= running_xor_d;
			current_id_q      <= current_id_d;
			selected_length_q <= selected_length_d;
		end
	end

	always_comb begin
		logic [7:0] sel;
		logic [7:0] x;
		phase_d           = phase_q;
		frame_length_d    = frame_length_q;
		bytes_seen_d      = bytes_seen_q;
		running_xor_d     = running_xor_q;
		current_id_d      = current_id_q;
		selected_length_d = selected_length_q;
		res_valid         = 1'b0;
		res.kind          = KIND_PAYLOAD;
		res.data_byte     = 8'd0;
		res.byte_index    = 8'd0;
		res.frame_id      = current_id_q;
		sel               = selected_length_q;
		x                 = running_xor_q ^ rx_byte;
		if (step) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == SYNC_FIRST) begin
						phase_d = PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					// A wrong second sync byte is dropped, not retried as a first sync.
					phase_d = (rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT;
				end
				PH_LEN: begin
					frame_length_d = rx_byte;
					phase_d        = PH_ID;
				end
				PH_ID: begin
					// Unknown ids keep whatever length was selected last.
					if (rx_byte == 8'd0) begin
						sel = len_id0;
					end else if (rx_byte == 8'd1) begin
						sel = len_id1;
					end
					current_id_d      = rx_byte;
					selected_length_d = sel;
					res.frame_id      = rx_byte;
					if (frame_length_q != sel) begin
						phase_d   = PH_HUNT;
						res_valid = 1'b1;
						res.kind  = KIND_MISMATCH;
					end else if (frame_length_q == 8'd0) begin
						phase_d = PH_HUNT;
					end else begin
						running_xor_d = frame_length_q ^ rx_byte;
						bytes_seen_d  = 8'd1;
						phase_d       = PH_BODY;
						res_valid     = 1'b1;
						res.data_byte = rx_byte;
					end
				end
				PH_BODY: begin
					running_xor_d = x;
					res_valid     = 1'b1;
					if (bytes_seen_q < frame_length_q) begin
						bytes_seen_d   = bytes_seen_q + 8'd1;
						res.data_byte  = rx_byte;
						res.byte_index = bytes_seen_q;
					end else begin
						// This beat is the checksum byte.
						phase_d  = PH_HUNT;
						res.kind = (x == 8'd0) ? KIND_GOOD : KIND_BAD;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	assign status.phase        = phase_q;
	assign status.frame_length = frame_length_q;
	assign status.bytes_seen   = bytes_seen_q;

endmodule

FILE: src/slxfr_out_reg.sv
// Result register of the frame receiver with valid/stall handshake.
// Tells the input stage when it may step. Uses slxfr_pkg.
module slxfr_out_reg import slxfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    res_valid,
	input  result_t res,
	input  logic    out_stall,
	output logic    ready,
	output logic    out_valid,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	// The register can take a new beat when empty or when its beat leaves now.
	assign ready = !(valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && step && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

FILE: src/sync_length_xor_frame_receiver.sv
// Top level of the sync/length/XOR frame receiver: input register, config
// registers, frame state machine and result register. Uses slxfr_pkg,
// slxfr_frame_fsm and slxfr_out_reg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | in_valid / in_stall  | rx_byte
//   out     | output    | out_valid / out_stall| kind, data_byte, byte_index, frame_id
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle is sustained while the output does not stall; each byte passes from
// the input register through the state machine into the result register.
// Reset clears the phase, counters, id, selected length and both valid bits;
// the length registers reset to one. A stall on the output holds the result and
// the input register; the input side stalls only when its register is full too.
// cfg_ready is always high.
module sync_length_xor_frame_receiver import slxfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             kind,
	output logic [7:0]             data_byte,
	output logic [7:0]             byte_index,
	output logic [7:0]             frame_id,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  len_id0_q;
	logic [7:0]  len_id1_q;
	logic        ready;
	logic        step;
	logic        accept;
	logic        res_valid;
	result_t     res;
	result_t     out_res;
	fsm_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_id0_q <= CFG_LEN_RESET;
			len_id1_q <= CFG_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEN_ID0: len_id0_q <= cfg_data;
				CFG_LEN_ID1: len_id1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step     = valid_s1 && ready;
	assign in_stall = valid_s1 && !ready;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !step);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	slxfr_frame_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.len_id0   (len_id0_q),
		.len_id1   (len_id1_q),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	slxfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.ready     (ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign kind       = out_res.kind;
	assign data_byte  = out_res.data_byte;
	assign byte_index = out_res.byte_index;
	assign frame_id   = out_res.frame_id;

	// Inside a frame body the byte count stays between one and the frame length.
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(status.phase == PH_BODY) |->
			(status.bytes_seen != 8'd0 && status.bytes_seen <= status.frame_length))
		else $error("byte count out of range in frame body");

	// An accepted beat lands in the input register on the next cycle.
	a_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (valid_s1 && byte_s1 == $past(rx_byte)))
		else $error("input beat not captured");

	// A held result register never steps the state machine.
	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !step)
		else $error("state machine stepped while result register held");

endmodule
